// File: rtl/core/tpcs_pkg.sv
// Shared types and constants for the transaction conflict sorter.
`default_nettype none

package tpcs_pkg;

    localparam int HI_W   = 32;
    localparam int WORD_W = 64;
    localparam int ADDR_W = HI_W + 2 * WORD_W;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Command from the sorting decision to the claimed-address set.
    typedef struct packed {
        logic en;     // insert the sender address
        logic two;    // insert the recipient address as well
        logic clear;  // end of block: empty the set
    } insert_t;

    // Answer from the claimed-address set for the item under test.
    typedef struct packed {
        logic snd_hit;
        logic dst_hit;
        logic free_one;
        logic free_two;
    } lookup_t;

    // Per-item fields produced by the block counters.
    typedef struct packed {
        idx_t tx_index;
        logic group_formed;
        cnt_t parallel_count;
        cnt_t serial_count;
    } count_res_t;

endpackage

`default_nettype wire

// File: rtl/core/tpcs_addr_set.sv
// Claimed-address set: parallel compare of two addresses and in-order insertion.
`default_nettype none

module tpcs_addr_set #(
    parameter int ADDR_SLOTS = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tpcs_pkg::addr_t   snd_addr,
    input  wire tpcs_pkg::addr_t   dst_addr,
    input  wire tpcs_pkg::insert_t ins,
    output tpcs_pkg::lookup_t      look
);

    localparam int FILL_W = $clog2(ADDR_SLOTS + 1);

    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [FILL_W-1:0]     fill_plus1;
    logic [ADDR_SLOTS-1:0] snd_hit_vec;
    logic [ADDR_SLOTS-1:0] dst_hit_vec;

    assign fill_plus1 = fill_reg + FILL_W'(1);

    // Slots are filled in order, so a slot is in use exactly when its index
    // lies below the fill count; no per-slot valid flag is needed.
    for (genvar g = 0; g < ADDR_SLOTS; g++) begin : g_slot
        localparam logic [FILL_W-1:0] SLOT_IDX = FILL_W'(g);
        tpcs_pkg::addr_t slot_reg;
        logic            in_use;

        assign in_use         = SLOT_IDX < fill_reg;
        assign snd_hit_vec[g] = in_use && (slot_reg == snd_addr);
        assign dst_hit_vec[g] = in_use && (slot_reg == dst_addr);

        always_ff @(posedge clk)
        begin
            if (ins.en && (SLOT_IDX == fill_reg))
            begin
                slot_reg <= snd_addr;
            end
            else if (ins.en && ins.two && (SLOT_IDX == fill_plus1))
            begin
                slot_reg <= dst_addr;
            end
        end
    end

    always_comb
    begin
        look.snd_hit  = |snd_hit_vec;
        look.dst_hit  = |dst_hit_vec;
        look.free_one = fill_reg < FILL_W'(ADDR_SLOTS);
        look.free_two = fill_reg < FILL_W'(ADDR_SLOTS - 1);
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ins.clear)
        begin
            fill_next = '0;
        end
        else if (ins.en)
        begin
            fill_next = ins.two ? fill_reg + FILL_W'(2) : fill_plus1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(ADDR_SLOTS))
        else $error("claimed set fill count exceeds the number of slots");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ins.clear |=> (fill_reg == '0))
        else $error("claimed set not empty after end of block");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tpcs_block_count.sv
// Per-block transaction and candidate counters with end-of-block totals.
`default_nettype none

module tpcs_block_count #(
    parameter int MAX_BLOCK_TX = 1024
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          cand,
    input  wire logic          last,
    output tpcs_pkg::count_res_t res
);

    localparam int TW = $clog2(MAX_BLOCK_TX + 1);

    logic [TW-1:0] tx_reg;
    logic [TW-1:0] tx_next;
    logic [TW-1:0] cand_reg;
    logic [TW-1:0] cand_next;
    logic [TW-1:0] tx_inc;
    logic [TW-1:0] cand_inc;
    logic [TW-1:0] idx_sat;
    logic [TW-1:0] par;
    logic          formed;

    always_comb
    begin
        tx_inc   = (tx_reg < TW'(MAX_BLOCK_TX)) ? tx_reg + TW'(1) : tx_reg;
        cand_inc = (cand && (cand_reg < TW'(MAX_BLOCK_TX))) ? cand_reg + TW'(1) : cand_reg;
        idx_sat  = (tx_reg > TW'(MAX_BLOCK_TX - 1)) ? TW'(MAX_BLOCK_TX - 1) : tx_reg;
        formed   = cand_inc > TW'(1);
        par      = formed ? cand_inc : '0;

        res.tx_index       = tpcs_pkg::idx_t'(idx_sat);
        res.group_formed   = last && formed;
        res.parallel_count = last ? tpcs_pkg::cnt_t'(par) : '0;
        res.serial_count   = last ? tpcs_pkg::cnt_t'(tx_inc - par) : '0;
    end

    always_comb
    begin
        tx_next   = tx_reg;
        cand_next = cand_reg;
        if (step)
        begin
            tx_next   = last ? '0 : tx_inc;
            cand_next = last ? '0 : cand_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_reg   <= '0;
            cand_reg <= '0;
        end
        else
        begin
            tx_reg   <= tx_next;
            cand_reg <= cand_next;
        end
    end

`ifndef SYNTHESIS
    a_cand_within_tx: assert property (@(posedge clk) disable iff (!rst_n)
        cand_reg <= tx_reg)
        else $error("candidate count exceeds transaction count");
`endif

endmodule

`default_nettype wire

// File: rtl/core/tx_parallel_conflict_sorter.sv
// Top level of the transaction conflict sorter: input register, decision and result register.
// Usage:
// Transactions of a block enter one per transfer on the input channel
// (in_valid / in_stall) and each gives exactly one result on the output
// channel (out_valid / out_stall), in order.
// A transfer is a parallel candidate when it decoded, is a plain transfer and
// neither address is already claimed in this block; its addresses are then
// claimed. With too few free slots it is serialised and set_overflow is set.
// The result of the item flagged last_in_block carries end_of_block, the
// group decision and the final counts; the claimed set and counters are then
// emptied for the next block.
// An accepted item is held in the input register and then in the result register.
// Throughput: one item per cycle while out_stall is low, limited by the
// combinational compare of both addresses against every claimed slot.
// Reset empties the pipeline, the claimed set and the counters.
// When the receiver stalls, the result register holds its transfer and the
// input register fills; in_stall then rises until the result is taken.
`default_nettype none

module tx_parallel_conflict_sorter #(
    parameter int MAX_BLOCK_TX = 1024,
    parameter int ADDR_SLOTS   = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          tx_valid,
    input  wire logic                          contract_create,
    input  wire logic                          has_data,
    input  wire logic [tpcs_pkg::HI_W-1:0]     sender_hi,
    input  wire logic [tpcs_pkg::WORD_W-1:0]   sender_mid,
    input  wire logic [tpcs_pkg::WORD_W-1:0]   sender_lo,
    input  wire logic [tpcs_pkg::HI_W-1:0]     dest_hi,
    input  wire logic [tpcs_pkg::WORD_W-1:0]   dest_mid,
    input  wire logic [tpcs_pkg::WORD_W-1:0]   dest_lo,
    input  wire logic                          last_in_block,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tpcs_pkg::IDX_W-1:0]         tx_index,
    output logic                               parallel_candidate,
    output logic                               set_overflow,
    output logic                               end_of_block,
    output logic                               group_formed,
    output logic [tpcs_pkg::CNT_W-1:0]         parallel_count,
    output logic [tpcs_pkg::CNT_W-1:0]         serial_count
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_plain_reg;
    logic              s1_last_reg;
    tpcs_pkg::addr_t   s1_snd_reg;
    tpcs_pkg::addr_t   s1_dst_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              res_cand_reg;
    logic              res_ovf_reg;
    logic              res_last_reg;
    tpcs_pkg::count_res_t res_cnt_reg;

    logic              in_take;
    logic              move;
    logic              same_addr;
    logic              no_conflict;
    logic              room;
    logic              cand;
    logic              ovf;
    tpcs_pkg::insert_t    ins;
    tpcs_pkg::lookup_t    look;
    tpcs_pkg::count_res_t cnt;

    // The stage-one item moves on when the result register is empty or
    // being emptied; the set and counters update at that same edge.
    assign move     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !move;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        same_addr   = s1_snd_reg == s1_dst_reg;
        no_conflict = s1_plain_reg && !look.snd_hit && !look.dst_hit;
        room        = same_addr ? look.free_one : look.free_two;
        cand        = no_conflict && room;
        ovf         = no_conflict && !room;
        ins.en      = move && cand;
        ins.two     = !same_addr;
        ins.clear   = move && s1_last_reg;
    end

    tpcs_addr_set #(
        .ADDR_SLOTS(ADDR_SLOTS)
    ) u_addr_set (
        .clk      (clk),
        .rst_n    (rst_n),
        .snd_addr (s1_snd_reg),
        .dst_addr (s1_dst_reg),
        .ins      (ins),
        .look     (look)
    );

    tpcs_block_count #(
        .MAX_BLOCK_TX(MAX_BLOCK_TX)
    ) u_block_count (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (move),
        .cand  (cand),
        .last  (s1_last_reg),
        .res   (cnt)
    );

    always_comb
    begin
        s1_valid_next  = in_take ? 1'b1 : (move ? 1'b0 : s1_valid_reg);
        out_valid_next = move ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_plain_reg <= tx_valid && !contract_create && !has_data;
            s1_last_reg  <= last_in_block;
            s1_snd_reg   <= {sender_hi, sender_mid, sender_lo};
            s1_dst_reg   <= {dest_hi, dest_mid, dest_lo};
        end
        if (move)
        begin
            res_cand_reg <= cand;
            res_ovf_reg  <= ovf;
            res_last_reg <= s1_last_reg;
            res_cnt_reg  <= cnt;
        end
    end

    assign out_valid          = out_valid_reg;
    assign tx_index           = res_cnt_reg.tx_index;
    assign parallel_candidate = res_cand_reg;
    assign set_overflow       = res_ovf_reg;
    assign end_of_block       = res_last_reg;
    assign group_formed       = res_cnt_reg.group_formed;
    assign parallel_count     = res_cnt_reg.parallel_count;
    assign serial_count       = res_cnt_reg.serial_count;

`ifndef SYNTHESIS
    a_cand_ovf_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(parallel_candidate && set_overflow))
        else $error("transfer both claimed and flagged as overflow");

    a_totals_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_block) |->
            (!group_formed && (parallel_count == '0) && (serial_count == '0)))
        else $error("block totals present on a result that does not end the block");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the transaction conflict sorter, with its own model of the block.
`default_nettype none

module tb;

    localparam int MAX_TX      = 1024;
    localparam int SLOTS       = 128;
    localparam int IDLE_LIMIT  = 1000;
    localparam int DRAIN_WAIT  = 8;
    localparam int POOL_SIZE   = 16;

    typedef struct {
        logic            ok;
        logic            create;
        logic            data;
        tpcs_pkg::addr_t snd;
        tpcs_pkg::addr_t dst;
        logic            last;
    } tx_item_t;

    typedef struct {
        tpcs_pkg::idx_t index;
        logic           cand;
        logic           ovf;
        logic           eob;
        logic           formed;
        tpcs_pkg::cnt_t par;
        tpcs_pkg::cnt_t ser;
    } sort_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          tx_valid = 1'b0;
    logic                          contract_create = 1'b0;
    logic                          has_data = 1'b0;
    logic [tpcs_pkg::HI_W-1:0]     sender_hi = '0;
    logic [tpcs_pkg::WORD_W-1:0]   sender_mid = '0;
    logic [tpcs_pkg::WORD_W-1:0]   sender_lo = '0;
    logic [tpcs_pkg::HI_W-1:0]     dest_hi = '0;
    logic [tpcs_pkg::WORD_W-1:0]   dest_mid = '0;
    logic [tpcs_pkg::WORD_W-1:0]   dest_lo = '0;
    logic                          last_in_block = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    tpcs_pkg::idx_t                tx_index;
    logic                          parallel_candidate;
    logic                          set_overflow;
    logic                          end_of_block;
    logic                          group_formed;
    tpcs_pkg::cnt_t                parallel_count;
    tpcs_pkg::cnt_t                serial_count;

    // Model state: the claimed addresses of the current block, in insertion order.
    tpcs_pkg::addr_t claimed[$];
    int              blk_txs;
    int              blk_cands;
    sort_res_t       pending_results[$];
    tpcs_pkg::addr_t addr_pool[POOL_SIZE];

    int gap_pct;
    int stall_pct;
    int errors = 0;
    int idle_cycles = 0;

    tx_parallel_conflict_sorter #(
        .MAX_BLOCK_TX(MAX_TX),
        .ADDR_SLOTS  (SLOTS)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .tx_valid          (tx_valid),
        .contract_create   (contract_create),
        .has_data          (has_data),
        .sender_hi         (sender_hi),
        .sender_mid        (sender_mid),
        .sender_lo         (sender_lo),
        .dest_hi           (dest_hi),
        .dest_mid          (dest_mid),
        .dest_lo           (dest_lo),
        .last_in_block     (last_in_block),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .tx_index          (tx_index),
        .parallel_candidate(parallel_candidate),
        .set_overflow      (set_overflow),
        .end_of_block      (end_of_block),
        .group_formed      (group_formed),
        .parallel_count    (parallel_count),
        .serial_count      (serial_count)
    );

    always #5 clk = ~clk;

    function automatic sort_res_t sort_tx(tx_item_t t);
        sort_res_t r;
        bit        hit;
        int        need;
        r = '{default: '0};
        r.index = tpcs_pkg::idx_t'((blk_txs > MAX_TX - 1) ? MAX_TX - 1 : blk_txs);
        if (t.ok && !t.create && !t.data)
        begin
            hit = 0;
            foreach (claimed[i])
                if (claimed[i] == t.snd || claimed[i] == t.dst)
                    hit = 1;
            if (!hit)
            begin
                need = (t.snd == t.dst) ? 1 : 2;
                if (SLOTS - claimed.size() >= need)
                begin
                    claimed.push_back(t.snd);
                    if (need == 2)
                        claimed.push_back(t.dst);
                    r.cand = 1'b1;
                end
                else
                    r.ovf = 1'b1;
            end
        end
        if (blk_txs < MAX_TX)
            blk_txs++;
        if (r.cand && blk_cands < MAX_TX)
            blk_cands++;
        r.eob = t.last;
        if (t.last)
        begin
            r.formed = (blk_cands > 1);
            r.par = tpcs_pkg::cnt_t'(r.formed ? blk_cands : 0);
            r.ser = tpcs_pkg::cnt_t'(blk_txs - (r.formed ? blk_cands : 0));
            claimed.delete();
            blk_txs = 0;
            blk_cands = 0;
        end
        return r;
    endfunction

    function automatic tx_item_t mk_tx(logic ok, logic create, logic data,
                                       tpcs_pkg::addr_t snd, tpcs_pkg::addr_t dst,
                                       logic last);
        tx_item_t t;
        t.ok = ok;
        t.create = create;
        t.data = data;
        t.snd = snd;
        t.dst = dst;
        t.last = last;
        return t;
    endfunction

    function automatic tpcs_pkg::addr_t rand_addr();
        return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    // Pool addresses give frequent conflicts; fresh ones fill the set.
    function automatic tpcs_pkg::addr_t pick_addr(bit fresh);
        if (fresh || $urandom_range(0, 2) == 0)
            return rand_addr();
        return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic tx_item_t rand_tx(bit fresh, logic last);
        tx_item_t t;
        int       kind;
        kind = $urandom_range(0, fresh ? 19 : 9);
        t.ok = (kind != 0);
        t.create = (kind == 1 || kind == 3 || (kind == 0 && $urandom_range(0, 1) == 1));
        t.data = (kind == 2 || kind == 3 || (kind == 0 && $urandom_range(0, 1) == 1));
        t.snd = pick_addr(fresh);
        t.dst = ($urandom_range(0, 9) == 0) ? t.snd : pick_addr(fresh);
        t.last = last;
        return t;
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 40;
        endcase
    endfunction

    function automatic void check_field(string name, tpcs_pkg::cnt_t want,
                                        tpcs_pkg::cnt_t got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic fill_pool();
        tpcs_pkg::addr_t flip;
        for (int i = 0; i < POOL_SIZE / 2; i++)
        begin
            addr_pool[i] = rand_addr();
            flip = tpcs_pkg::addr_t'(1) << $urandom_range(0, tpcs_pkg::ADDR_W - 1);
            addr_pool[i + POOL_SIZE / 2] = addr_pool[i] ^ flip;
        end
    endtask

    task automatic send_tx(input tx_item_t t);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        tx_valid        <= t.ok;
        contract_create <= t.create;
        has_data        <= t.data;
        sender_hi       <= t.snd[tpcs_pkg::ADDR_W-1 -: tpcs_pkg::HI_W];
        sender_mid      <= t.snd[2*tpcs_pkg::WORD_W-1 -: tpcs_pkg::WORD_W];
        sender_lo       <= t.snd[tpcs_pkg::WORD_W-1:0];
        dest_hi         <= t.dst[tpcs_pkg::ADDR_W-1 -: tpcs_pkg::HI_W];
        dest_mid        <= t.dst[2*tpcs_pkg::WORD_W-1 -: tpcs_pkg::WORD_W];
        dest_lo         <= t.dst[tpcs_pkg::WORD_W-1:0];
        last_in_block   <= t.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(sort_tx(t));
    endtask

    task automatic end_stream();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_blocks(input int n_items, input bit idling);
        int sent;
        int len;
        bit fresh;
        sent = 0;
        while (sent < n_items)
        begin
            fresh = ($urandom_range(0, 11) == 0);
            len = fresh ? $urandom_range(80, 100) : $urandom_range(1, 30);
            gap_pct = idling ? pick_rate() : 0;
            stall_pct = idling ? pick_rate() : 0;
            for (int k = 0; k < len; k++)
                send_tx(rand_tx(fresh, k == len - 1));
            sent += len;
        end
        end_stream();
    endtask

    task automatic test_directed();
        tpcs_pkg::addr_t ones;
        tpcs_pkg::addr_t zero;
        tpcs_pkg::addr_t top_off;
        tpcs_pkg::addr_t top_bit;
        tpcs_pkg::addr_t r;
        ones = '1;
        zero = '0;
        top_off = {1'b0, {(tpcs_pkg::ADDR_W-1){1'b1}}};
        top_bit = {1'b1, {(tpcs_pkg::ADDR_W-1){1'b0}}};
        gap_pct = 20;
        stall_pct = 20;
        // Undecoded, create and call-data items claim nothing.
        send_tx(mk_tx(1'b0, 1'b1, 1'b1, ones, ones, 1'b0));
        send_tx(mk_tx(1'b1, 1'b1, 1'b0, rand_addr(), rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b1, rand_addr(), rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b1, 1'b1, rand_addr(), rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, ones, zero, 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, ones, rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, rand_addr(), zero, 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, zero, rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, top_off, top_off, 1'b0));
        // Near misses: one bit away from claimed addresses.
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, tpcs_pkg::addr_t'(1), top_bit, 1'b0));
        send_tx(mk_tx(1'b0, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b1));
        // A single-item block, and one with a lone candidate: no group forms.
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, ones, zero, 1'b1));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, ones, zero, 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, zero, rand_addr(), 1'b1));
        r = rand_addr();
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, r, r, 1'b1));
        end_stream();
    endtask

    task automatic test_set_full();
        tpcs_pkg::addr_t first;
        tpcs_pkg::addr_t a;
        gap_pct = 10;
        stall_pct = 10;
        first = rand_addr();
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, first, rand_addr(), 1'b0));
        for (int i = 1; i < SLOTS / 2 - 1; i++)
            send_tx(mk_tx(1'b1, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b0));
        a = rand_addr();
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, a, a, 1'b0));
        // One slot left: a pair does not fit, a conflict is still plain serial.
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, first, rand_addr(), 1'b0));
        a = rand_addr();
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, a, a, 1'b0));
        a = rand_addr();
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, a, a, 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b0));
        send_tx(mk_tx(1'b1, 1'b0, 1'b0, rand_addr(), first, 1'b0));
        send_tx(mk_tx(1'b0, 1'b0, 1'b0, rand_addr(), rand_addr(), 1'b1));
        end_stream();
    endtask

    task automatic test_random_blocks();
        run_blocks(560, 1'b1);
    endtask

    task automatic test_quiet_tail();
        run_blocks(150, 1'b0);
    endtask

    // Receiver side: out_stall is raised in bursts, started at the rate stall_pct.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
                burst--;
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
                burst = $urandom_range(1, 3);
            out_stall <= (burst != 0);
        end
    end

    always @(posedge clk)
    begin
        sort_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, tx_index %0d", $time, tx_index);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("tx_index", tpcs_pkg::cnt_t'(want.index),
                            tpcs_pkg::cnt_t'(tx_index));
                check_field("parallel_candidate", tpcs_pkg::cnt_t'(want.cand),
                            tpcs_pkg::cnt_t'(parallel_candidate));
                check_field("set_overflow", tpcs_pkg::cnt_t'(want.ovf),
                            tpcs_pkg::cnt_t'(set_overflow));
                check_field("end_of_block", tpcs_pkg::cnt_t'(want.eob),
                            tpcs_pkg::cnt_t'(end_of_block));
                check_field("group_formed", tpcs_pkg::cnt_t'(want.formed),
                            tpcs_pkg::cnt_t'(group_formed));
                check_field("parallel_count", want.par, parallel_count);
                check_field("serial_count", want.ser, serial_count);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a transfer.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        gap_pct = 0;
        stall_pct = 0;
        blk_txs = 0;
        blk_cands = 0;
        fill_pool();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_set_full();
        test_random_blocks();
        test_quiet_tail();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
